// ----- rtl/rc_satellite_frame_decode_bar_display_defines.svh -----
// Assertion macros of the frame decoder and bar display RTL, used by the queue.
// Needs signals named clock and reset in the module that uses them.
`ifndef RC_SATELLITE_FRAME_DECODE_BAR_DISPLAY_DEFINES_SVH
`define RC_SATELLITE_FRAME_DECODE_BAR_DISPLAY_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define RCSFD_ASSERT_SAME(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("rcsfd same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define RCSFD_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("rcsfd next-cycle check failed");

`endif

// ----- rtl/rcsfd_pkg.sv -----
// Types and constants for the satellite frame decoder and bar display.
// No dependencies; used by every other RTL file of the block but the assertion defines header.
`default_nettype none
package rcsfd_pkg;

   localparam int CHAN_W      = 3;
   localparam int VALUE_W     = 11;
   localparam int COL_W       = 7;
   localparam int PIXEL_W     = 8;
   localparam int BAR_SHIFT   = 4;
   localparam int CHANNELS    = 8;
   localparam int BAR_COLUMNS = 128;

   localparam logic [CHAN_W-1:0]  LAST_ROW  = CHAN_W'(CHANNELS - 1);
   localparam logic [COL_W-1:0]   LAST_COL  = COL_W'(BAR_COLUMNS - 1);
   localparam logic [PIXEL_W-1:0] PIXEL_LIT = 8'hFF;
   localparam logic [PIXEL_W-1:0] PIXEL_OFF = 8'h00;

   // Queue between the front and back parts (depth is a power of two).
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      KIND_UPDATE = 1'b0,
      KIND_PIXEL  = 1'b1
   } kind_type;

   localparam logic ACTION_RX_BYTE = 1'b0;

   // One classified operation: an update carries the 11-bit value, a pixel
   // carries the column in the low bits of value.
   typedef struct packed {
      kind_type            kind;
      logic [CHAN_W-1:0]   id;
      logic [VALUE_W-1:0]  value;
      logic                last;
   } op_type;

endpackage
`default_nettype wire

// ----- rtl/rcsfd_req_if.sv -----
// Input and result channel interfaces of the frame decoder.
// Depends on rcsfd_pkg for field widths.
`default_nettype none
interface rcsfd_req_if;
   logic                           valid;
   logic                           ready;
   logic                           action;
   logic [7:0]                     rx_byte;

   modport source (output valid, output action, output rx_byte, input ready);
   modport sink (input valid, input action, input rx_byte, output ready);
endinterface

interface rcsfd_rsp_if;
   logic                            valid;
   logic                            ready;
   logic                            kind;
   logic [rcsfd_pkg::CHAN_W-1:0]    channel_id;
   logic [rcsfd_pkg::VALUE_W-1:0]   channel_value;
   logic [rcsfd_pkg::PIXEL_W-1:0]   pixel_byte;
   logic                            last_of_screen;

   modport source (output valid, output kind, output channel_id, output channel_value,
                   output pixel_byte, output last_of_screen, input ready);
   modport sink (input valid, input kind, input channel_id, input channel_value,
                 input pixel_byte, input last_of_screen, output ready);
endinterface
`default_nettype wire

// ----- rtl/rcsfd_front.sv -----
// Front part: accepts input transfers, tracks frame position and display
// scan position, and classifies each item into an operation. Uses rcsfd_pkg.
`default_nettype none
module rcsfd_front #(
   parameter int FRAME_BYTES = 16
) (
   input  wire                   clock,
   input  wire                   reset,
   rcsfd_req_if.sink             req,
   input  wire                   op_space,
   output logic                  op_push,
   output rcsfd_pkg::op_type     op_data
);

   localparam int POS_W = $clog2(FRAME_BYTES);
   localparam logic [POS_W-1:0] LAST_POS = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] FIRST_LOW = POS_W'(3);

   logic [POS_W-1:0]             pos_ff, pos_in;
   logic [7:0]                   high_ff, high_in;
   logic [rcsfd_pkg::CHAN_W-1:0] row_ff, row_in;
   logic [rcsfd_pkg::COL_W-1:0]  col_ff, col_in;
   logic                         accept;
   logic                         is_rx;

   assign req.ready = op_space;
   assign accept    = req.valid && op_space;
   assign is_rx     = (req.action == rcsfd_pkg::ACTION_RX_BYTE);

   always_comb begin
      pos_in  = pos_ff;
      high_in = high_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      op_push = 1'b0;
      op_data.kind  = rcsfd_pkg::KIND_PIXEL;
      op_data.id    = row_ff;
      op_data.value = rcsfd_pkg::VALUE_W'(col_ff);
      op_data.last  = (row_ff == rcsfd_pkg::LAST_ROW) && (col_ff == rcsfd_pkg::LAST_COL);
      if (is_rx) begin
         op_data.kind  = rcsfd_pkg::KIND_UPDATE;
         op_data.id    = high_ff[5:3];
         op_data.value = {high_ff[2:0], req.rx_byte};
         op_data.last  = 1'b0;
      end
      if (accept) begin
         if (is_rx) begin
            op_push = pos_ff[0] && (pos_ff >= FIRST_LOW);
            high_in = req.rx_byte;
            pos_in  = (pos_ff == LAST_POS) ? '0 : pos_ff + POS_W'(1);
         end else begin
            op_push = 1'b1;
            col_in  = col_ff + rcsfd_pkg::COL_W'(1);
            if (col_ff == rcsfd_pkg::LAST_COL) begin
               row_in = row_ff + rcsfd_pkg::CHAN_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff  <= '0;
         high_ff <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         pos_ff  <= pos_in;
         high_ff <= high_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

endmodule
`default_nettype wire

// ----- rtl/rcsfd_queue.sv -----
// Short operation queue between the front and back parts.
// Uses rcsfd_pkg for the operation type and queue depth.
`default_nettype none
`include "rc_satellite_frame_decode_bar_display_defines.svh"
module rcsfd_queue (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   push,
   input  rcsfd_pkg::op_type     push_data,
   output logic                  space,
   input  wire                   pop,
   output logic                  filled,
   output rcsfd_pkg::op_type     pop_data
);

   rcsfd_pkg::op_type              slot_ff [rcsfd_pkg::QUEUE_DEPTH];
   logic [rcsfd_pkg::QPTR_W-1:0]   wr_ff, wr_in;
   logic [rcsfd_pkg::QPTR_W-1:0]   rd_ff, rd_in;
   logic [rcsfd_pkg::QCNT_W-1:0]   count_ff, count_in;

   assign space    = (count_ff != rcsfd_pkg::QCNT_W'(rcsfd_pkg::QUEUE_DEPTH));
   assign filled   = (count_ff != '0);
   assign pop_data = slot_ff[rd_ff];

   always_comb begin
      wr_in    = push ? wr_ff + rcsfd_pkg::QPTR_W'(1) : wr_ff;
      rd_in    = pop ? rd_ff + rcsfd_pkg::QPTR_W'(1) : rd_ff;
      count_in = count_ff;
      if (push && !pop) begin
         count_in = count_ff + rcsfd_pkg::QCNT_W'(1);
      end else if (pop && !push) begin
         count_in = count_ff - rcsfd_pkg::QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
   end

   `RCSFD_ASSERT_SAME(a_no_overflow, push, space)
   `RCSFD_ASSERT_SAME(a_no_underflow, pop, filled)
   `RCSFD_ASSERT_NEXT(a_count_grows, push && !pop, count_ff == $past(count_ff) + rcsfd_pkg::QCNT_W'(1))

endmodule
`default_nettype wire

// ----- rtl/rcsfd_back.sv -----
// Back part: holds the channel values, applies updates, renders bar pixels
// and drives the registered result channel. Uses rcsfd_pkg.
`default_nettype none
module rcsfd_back (
   input  wire                   clock,
   input  wire                   reset,
   input  wire                   op_filled,
   input  rcsfd_pkg::op_type     op_data,
   output logic                  op_pop,
   rcsfd_rsp_if.source           rsp
);

   logic [rcsfd_pkg::VALUE_W-1:0]  chan_ff [rcsfd_pkg::CHANNELS];
   logic                           valid_ff;
   logic                           kind_ff;
   logic [rcsfd_pkg::CHAN_W-1:0]   id_ff;
   logic [rcsfd_pkg::VALUE_W-1:0]  value_ff, value_in;
   logic [rcsfd_pkg::PIXEL_W-1:0]  pixel_ff, pixel_in;
   logic                           last_ff;
   logic [rcsfd_pkg::COL_W-1:0]    limit;
   logic                           is_update;

   assign op_pop    = op_filled && (!valid_ff || rsp.ready);
   assign is_update = (op_data.kind == rcsfd_pkg::KIND_UPDATE);
   assign limit     = rcsfd_pkg::COL_W'(chan_ff[op_data.id] >> rcsfd_pkg::BAR_SHIFT);

   always_comb begin
      value_in = '0;
      pixel_in = rcsfd_pkg::PIXEL_OFF;
      if (is_update) begin
         value_in = op_data.value;
      end else if (op_data.value[rcsfd_pkg::COL_W-1:0] < limit) begin
         pixel_in = rcsfd_pkg::PIXEL_LIT;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         for (int i = 0; i < rcsfd_pkg::CHANNELS; i++) begin
            chan_ff[i] <= '0;
         end
      end else begin
         if (op_pop) begin
            valid_ff <= 1'b1;
         end else if (rsp.ready) begin
            valid_ff <= 1'b0;
         end
         if (op_pop && is_update) begin
            chan_ff[op_data.id] <= op_data.value;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         kind_ff  <= op_data.kind;
         id_ff    <= op_data.id;
         value_ff <= value_in;
         pixel_ff <= pixel_in;
         last_ff  <= op_data.last;
      end
   end

   assign rsp.valid          = valid_ff;
   assign rsp.kind           = kind_ff;
   assign rsp.channel_id     = id_ff;
   assign rsp.channel_value  = value_ff;
   assign rsp.pixel_byte     = pixel_ff;
   assign rsp.last_of_screen = last_ff;

endmodule
`default_nettype wire

// ----- rtl/rc_satellite_frame_decode_bar_display.sv -----
// Top level of the satellite frame decoder with bar-graph display feed.
// Depends on rcsfd_pkg, the channel interfaces, front, queue and back.
//
//   Channel   Direction  Carries
//   req_bus   in         action, rx_byte
//   rsp_bus   out        kind, channel_id, channel_value, pixel_byte, last_of_screen
//
// One item is accepted per cycle while the queue has space; a result passes
// the queue slot and then the result register before it appears on rsp_bus.
// Header and high bytes pass the front part only and yield no result.
// The two-entry queue keeps input taken while a result waits on rsp_bus.
// Synchronous reset clears positions, scan counters and all channel values.
`default_nettype none
module rc_satellite_frame_decode_bar_display #(
   parameter int FRAME_BYTES = 16
) (
   input  wire          clock,
   input  wire          reset,
   rcsfd_req_if.sink    req_bus,
   rcsfd_rsp_if.source  rsp_bus
);

   logic              push;
   logic              space;
   logic              pop;
   logic              filled;
   rcsfd_pkg::op_type push_data;
   rcsfd_pkg::op_type pop_data;

   rcsfd_front #(
      .FRAME_BYTES(FRAME_BYTES)
   ) u_front (
      .clock    (clock),
      .reset    (reset),
      .req      (req_bus),
      .op_space (space),
      .op_push  (push),
      .op_data  (push_data)
   );

   rcsfd_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .space     (space),
      .pop       (pop),
      .filled    (filled),
      .pop_data  (pop_data)
   );

   rcsfd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .op_filled (filled),
      .op_data   (pop_data),
      .op_pop    (pop),
      .rsp       (rsp_bus)
   );

endmodule
`default_nettype wire

// ----- tb/rc_satellite_frame_decode_bar_display_tb.sv -----
// Self-checking testbench for the satellite frame decoder with bar-graph display feed.
// Needs rcsfd_pkg and the rcsfd_req_if/rcsfd_rsp_if interfaces; a built-in predictor
// checks every result transfer against a directed table and random frames and ticks.
module rc_satellite_frame_decode_bar_display_tb;

   localparam int   FRAME_BYTES          = 16;
   localparam int   RANDOM_ITEMS         = 1300;
   localparam int   DRAIN_CYCLES         = 20;
   localparam logic ACTION_RX_BYTE       = rcsfd_pkg::ACTION_RX_BYTE;
   localparam logic ACTION_DISPLAY_TICK  = ~rcsfd_pkg::ACTION_RX_BYTE;

   localparam rcsfd_pkg::kind_type KIND_UPDATE = rcsfd_pkg::KIND_UPDATE;
   localparam rcsfd_pkg::kind_type KIND_PIXEL  = rcsfd_pkg::KIND_PIXEL;
   localparam logic [rcsfd_pkg::PIXEL_W-1:0] PIXEL_LIT = rcsfd_pkg::PIXEL_LIT;
   localparam logic [rcsfd_pkg::PIXEL_W-1:0] PIXEL_OFF = rcsfd_pkg::PIXEL_OFF;

   typedef struct packed {
      rcsfd_pkg::kind_type            kind;
      logic [rcsfd_pkg::CHAN_W-1:0]   id;
      logic [rcsfd_pkg::VALUE_W-1:0]  value;
      logic [rcsfd_pkg::PIXEL_W-1:0]  pixel;
      logic                           last;
   } decoded_result_type;

   typedef struct packed {
      logic                action;
      logic [7:0]          rx;
      logic                typed;
      logic                has_rsp;
      decoded_result_type  rsp;
   } stim_row_type;

   localparam decoded_result_type NO_RSP = '0;

   logic clock = 1'b0;
   logic reset = 1'b1;

   rcsfd_req_if req_if();
   rcsfd_rsp_if rsp_if();

   rc_satellite_frame_decode_bar_display i_dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_if),
      .rsp_bus (rsp_if)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Predictor state.
   logic [3:0]                     frame_pos;
   logic [7:0]                     prior_byte;
   logic [rcsfd_pkg::VALUE_W-1:0]  stored_values [rcsfd_pkg::CHANNELS];
   logic [rcsfd_pkg::CHAN_W-1:0]   scan_row;
   logic [rcsfd_pkg::COL_W-1:0]    scan_col;

   decoded_result_type pending_results [$];
   int  errors = 0;
   int  sent = 0;
   int  updates_seen = 0;
   int  pixels_seen = 0;
   int  screens_seen = 0;
   bit  steady = 1'b0;
   int  ready_hold = 0;

   stim_row_type directed_rows [22] = '{
      '{ACTION_DISPLAY_TICK, 8'hA5, 1'b1, 1'b1, '{KIND_PIXEL, 3'd0, 11'd0, PIXEL_OFF, 1'b0}},
      '{ACTION_RX_BYTE, 8'h00, 1'b1, 1'b0, NO_RSP},
      '{ACTION_RX_BYTE, 8'hFF, 1'b1, 1'b0, NO_RSP},
      '{ACTION_RX_BYTE, 8'hFF, 1'b1, 1'b0, NO_RSP},
      '{ACTION_RX_BYTE, 8'hFF, 1'b1, 1'b1, '{KIND_UPDATE, 3'd7, 11'd2047, PIXEL_OFF, 1'b0}},
      '{ACTION_RX_BYTE, 8'h00, 1'b1, 1'b0, NO_RSP},
      '{ACTION_RX_BYTE, 8'h00, 1'b1, 1'b1, '{KIND_UPDATE, 3'd0, 11'd0, PIXEL_OFF, 1'b0}},
      '{ACTION_RX_BYTE, 8'h07, 1'b1, 1'b0, NO_RSP},
      '{ACTION_RX_BYTE, 8'hFF, 1'b1, 1'b1, '{KIND_UPDATE, 3'd0, 11'd2047, PIXEL_OFF, 1'b0}},
      '{ACTION_DISPLAY_TICK, 8'h5A, 1'b1, 1'b1, '{KIND_PIXEL, 3'd0, 11'd0, PIXEL_LIT, 1'b0}},
      '{ACTION_RX_BYTE, 8'h38, 1'b0, 1'b0, NO_RSP},
      '{ACTION_RX_BYTE, 8'h10, 1'b0, 1'b0, NO_RSP},
      '{ACTION_RX_BYTE, 8'h2D, 1'b0, 1'b0, NO_RSP},
      '{ACTION_RX_BYTE, 8'hA5, 1'b0, 1'b0, NO_RSP},
      '{ACTION_DISPLAY_TICK, 8'hFF, 1'b0, 1'b0, NO_RSP},
      '{ACTION_RX_BYTE, 8'h18, 1'b0, 1'b0, NO_RSP},
      '{ACTION_RX_BYTE, 8'h00, 1'b0, 1'b0, NO_RSP},
      '{ACTION_RX_BYTE, 8'h3F, 1'b0, 1'b0, NO_RSP},
      '{ACTION_RX_BYTE, 8'h80, 1'b0, 1'b0, NO_RSP},
      '{ACTION_RX_BYTE, 8'h55, 1'b1, 1'b0, NO_RSP},
      '{ACTION_RX_BYTE, 8'hAA, 1'b1, 1'b0, NO_RSP},
      '{ACTION_DISPLAY_TICK, 8'h00, 1'b0, 1'b0, NO_RSP}
   };

   function automatic bit decode_and_scan(input logic act, input logic [7:0] rx,
                                          output decoded_result_type res);
      logic [rcsfd_pkg::CHAN_W-1:0]  ch;
      logic [rcsfd_pkg::VALUE_W-1:0] val;
      bit                            produced;
      produced = 1'b0;
      res = NO_RSP;
      if (act == ACTION_RX_BYTE) begin
         if (frame_pos[0] && frame_pos >= 4'd3) begin
            ch = prior_byte[5:3];
            val = {prior_byte[2:0], rx};
            stored_values[ch] = val;
            res = '{KIND_UPDATE, ch, val, PIXEL_OFF, 1'b0};
            produced = 1'b1;
         end
         prior_byte = rx;
         frame_pos = (int'(frame_pos) + 1 >= FRAME_BYTES) ? 4'd0 : frame_pos + 4'd1;
      end else begin
         res.kind = KIND_PIXEL;
         res.id = scan_row;
         res.value = '0;
         res.pixel = (scan_col < rcsfd_pkg::COL_W'(stored_values[scan_row] >>
                                                   rcsfd_pkg::BAR_SHIFT)) ?
                     PIXEL_LIT : PIXEL_OFF;
         res.last = (scan_row == rcsfd_pkg::LAST_ROW) && (scan_col == rcsfd_pkg::LAST_COL);
         if (scan_col == rcsfd_pkg::LAST_COL) scan_row = scan_row + 1'b1;
         scan_col = scan_col + 1'b1;
         produced = 1'b1;
      end
      return produced;
   endfunction

   // Mostly short gaps, now and then a long one.
   function automatic int idle_length();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   task automatic push_item(input logic act, input logic [7:0] rx, input logic typed,
                            input logic typed_has, input decoded_result_type typed_rsp);
      int                 gap;
      decoded_result_type res;
      bit                 produced;
      gap = steady ? 0 : idle_length();
      if ($urandom_range(0, 149) == 0) steady = ~steady;
      if (gap > 0) begin
         @(negedge clock);
         req_if.valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_if.valid   <= 1'b1;
      req_if.action  <= act;
      req_if.rx_byte <= rx;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
      produced = decode_and_scan(act, rx, res);
      if (typed) begin
         if (typed_has) pending_results.push_back(typed_rsp);
      end else if (produced) begin
         pending_results.push_back(res);
      end
      sent++;
   endtask

   function automatic logic [7:0] frame_byte();
      case ($urandom_range(0, 9))
         0: return 8'h00;
         1: return 8'hFF;
         default: return 8'($urandom);
      endcase
   endfunction

   // Result side: random back-pressure in stretches.
   initial begin
      rsp_if.ready = 1'b1;
      forever begin
         @(negedge clock);
         if (steady) begin
            rsp_if.ready <= 1'b1;
         end else if (ready_hold > 0) begin
            ready_hold--;
         end else if ($urandom_range(0, 1) == 0) begin
            rsp_if.ready <= 1'b1;
            ready_hold = $urandom_range(0, 12);
         end else begin
            rsp_if.ready <= 1'b0;
            ready_hold = idle_length();
         end
      end
   end

   always @(posedge clock) begin
      decoded_result_type exp;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (pending_results.size() == 0) begin
            $error("result transfer with no expectation waiting");
            errors++;
         end else begin
            exp = pending_results.pop_front();
            if (rsp_if.kind !== exp.kind) begin
               $error("kind mismatch: expected %0d, got %0d", exp.kind, rsp_if.kind);
               errors++;
            end
            if (rsp_if.channel_id !== exp.id) begin
               $error("channel_id mismatch: expected %0d, got %0d",
                      exp.id, rsp_if.channel_id);
               errors++;
            end
            if (rsp_if.channel_value !== exp.value) begin
               $error("channel_value mismatch: expected %0d, got %0d",
                      exp.value, rsp_if.channel_value);
               errors++;
            end
            if (rsp_if.pixel_byte !== exp.pixel) begin
               $error("pixel_byte mismatch: expected %0d, got %0d",
                      exp.pixel, rsp_if.pixel_byte);
               errors++;
            end
            if (rsp_if.last_of_screen !== exp.last) begin
               $error("last_of_screen mismatch: expected %0d, got %0d",
                      exp.last, rsp_if.last_of_screen);
               errors++;
            end
            if (exp.kind == KIND_UPDATE) updates_seen++;
            else pixels_seen++;
            if (exp.last) screens_seen++;
         end
      end
   end

   initial begin
      #10_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      int mode;
      int len;
      req_if.valid   = 1'b0;
      req_if.action  = ACTION_RX_BYTE;
      req_if.rx_byte = 8'h00;
      frame_pos  = '0;
      prior_byte = '0;
      scan_row   = '0;
      scan_col   = '0;
      for (int i = 0; i < rcsfd_pkg::CHANNELS; i++) stored_values[i] = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         push_item(directed_rows[i].action, directed_rows[i].rx, directed_rows[i].typed,
                   directed_rows[i].has_rsp, directed_rows[i].rsp);

      // Tick bursts walk the screen; partial frames and single items shift the alignment.
      while (sent < RANDOM_ITEMS) begin
         mode = $urandom_range(0, 9);
         if (mode < 2) begin
            for (int b = 0; b < FRAME_BYTES; b++) begin
               if ($urandom_range(0, 7) == 0)
                  push_item(ACTION_DISPLAY_TICK, 8'($urandom), 1'b0, 1'b0, NO_RSP);
               push_item(ACTION_RX_BYTE, frame_byte(), 1'b0, 1'b0, NO_RSP);
            end
         end else if (mode < 8) begin
            len = $urandom_range(1, 60);
            repeat (len) push_item(ACTION_DISPLAY_TICK, 8'($urandom), 1'b0, 1'b0, NO_RSP);
         end else if (mode == 8) begin
            push_item(1'($urandom), 8'($urandom), 1'b0, 1'b0, NO_RSP);
         end else begin
            len = $urandom_range(1, FRAME_BYTES - 1);
            repeat (len) push_item(ACTION_RX_BYTE, frame_byte(), 1'b0, 1'b0, NO_RSP);
         end
      end

      @(negedge clock);
      req_if.valid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Sent %0d input transfers; checked %0d channel updates and %0d display bytes,",
               sent, updates_seen, pixels_seen);
      $display("including %0d complete bar-graph screens.", screens_seen);
      if (errors == 0) begin
         $display("TEST PASSED");
      end else begin
         $display("TEST FAILED");
      end
      $finish;
   end

endmodule
